// ===== rtl/prp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_pkg
// Shared types and constants for the patch record parser.
// ----------------------------------------------------------------------------
package prp_pkg;

  localparam int unsigned ADDR_WIDTH_DEF = 32;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned CFG_W  = 32;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FILL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  localparam logic [0:0] REG_PATCH_FORMAT = 1'b0;
  localparam logic [0:0] REG_ROM_SIZE     = 1'b1;

  localparam logic [23:0] IPS_END_MARK = 24'h454F46;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } prp_result_t;

endpackage

// ===== rtl/prp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_parser
// Record state machine: consumes one byte per step and yields at most one
// command.
// ----------------------------------------------------------------------------
module prp_parser #(
  parameter int unsigned ADDRESS_WIDTH = prp_pkg::ADDR_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [prp_pkg::DATA_W-1:0] byte_in,
  input  logic                      aps,
  input  logic [prp_pkg::CFG_W-1:0] rom_size,
  output logic                      res_valid,
  output prp_pkg::prp_result_t      res
);
  import prp_pkg::*;

  localparam logic [2:0] PH_OFFSET   = 3'd0;
  localparam logic [2:0] PH_COUNT    = 3'd1;
  localparam logic [2:0] PH_DATA     = 3'd2;
  localparam logic [2:0] PH_IPS_RUN  = 3'd3;
  localparam logic [2:0] PH_IPS_FILL = 3'd4;
  localparam logic [2:0] PH_APS_VAL  = 3'd5;
  localparam logic [2:0] PH_APS_RUN  = 3'd6;

  localparam logic [ADDR_W-1:0] ADDR_MASK =
    ADDR_W'((64'd1 << ADDRESS_WIDTH) - 64'd1);

  logic [2:0]        phase_r, phase_nxt;
  logic [ADDR_W-1:0] off_r, off_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic [DATA_W-1:0] held_r, held_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic              ended_r, ended_nxt;

  logic [ADDR_W-1:0] off_base;
  logic [ADDR_W-1:0] off_sh;
  logic [2:0]        idx_inc;

  always_comb begin
    off_base = (idx_r == 3'd0) ? '0 : off_r;
    case (idx_r[1:0])
      2'd0:    off_sh = {24'd0, byte_in};
      2'd1:    off_sh = {16'd0, byte_in, 8'd0};
      2'd2:    off_sh = {8'd0, byte_in, 16'd0};
      default: off_sh = {byte_in, 24'd0};
    endcase
    idx_inc = idx_r + 3'd1;
  end

  always_comb begin
    phase_nxt = phase_r;
    off_nxt   = off_r;
    left_nxt  = left_r;
    held_nxt  = held_r;
    idx_nxt   = idx_r;
    ended_nxt = ended_r;
    res_valid = 1'b0;
    res       = '0;
    if (!ended_r) begin
      case (phase_r)
        PH_OFFSET: begin
          off_nxt = aps ? (off_base | off_sh) : {off_base[23:0], byte_in};
          idx_nxt = idx_inc;
          if (aps && idx_inc >= 3'd4) begin
            idx_nxt = '0;
            if (off_nxt > rom_size) begin
              ended_nxt = 1'b1;
              res_valid = 1'b1;
              res.kind  = KIND_END;
            end else begin
              phase_nxt = PH_COUNT;
            end
          end else if (!aps && idx_inc >= 3'd3) begin
            idx_nxt = '0;
            off_nxt = {8'd0, off_nxt[23:0]};
            if (off_nxt[23:0] == IPS_END_MARK) begin
              ended_nxt = 1'b1;
              res_valid = 1'b1;
              res.kind  = KIND_END;
            end else begin
              phase_nxt = PH_COUNT;
              left_nxt  = '0;
            end
          end
        end
        PH_COUNT: begin
          if (aps) begin
            idx_nxt   = '0;
            left_nxt  = {8'd0, byte_in};
            phase_nxt = (byte_in != '0) ? PH_DATA : PH_APS_VAL;
          end else if (idx_r == 3'd0) begin
            left_nxt = {byte_in, 8'd0};
            idx_nxt  = 3'd1;
          end else begin
            idx_nxt   = '0;
            left_nxt  = {left_r[15:8], byte_in};
            phase_nxt = (left_nxt != '0) ? PH_DATA : PH_IPS_RUN;
          end
        end
        PH_DATA: begin
          res_valid = 1'b1;
          res.kind  = KIND_WRITE;
          res.addr  = off_r & ADDR_MASK;
          res.data  = byte_in;
          res.len   = LEN_W'(1);
          off_nxt   = off_r + ADDR_W'(1);
          left_nxt  = left_r - LEN_W'(1);
          if (left_nxt == '0) begin
            phase_nxt = PH_OFFSET;
            idx_nxt   = '0;
          end
        end
        PH_IPS_RUN: begin
          if (idx_r == 3'd0) begin
            left_nxt = {byte_in, 8'd0};
            idx_nxt  = 3'd1;
          end else begin
            idx_nxt   = '0;
            left_nxt  = {left_r[15:8], byte_in};
            phase_nxt = PH_IPS_FILL;
          end
        end
        PH_IPS_FILL: begin
          held_nxt  = byte_in;
          phase_nxt = PH_OFFSET;
          idx_nxt   = '0;
          if (left_r != '0) begin
            res_valid = 1'b1;
            res.kind  = KIND_FILL;
            res.addr  = off_r & ADDR_MASK;
            res.data  = byte_in;
            res.len   = left_r;
          end
        end
        PH_APS_VAL: begin
          held_nxt  = byte_in;
          phase_nxt = PH_APS_RUN;
        end
        PH_APS_RUN: begin
          left_nxt  = {8'd0, byte_in};
          phase_nxt = PH_OFFSET;
          idx_nxt   = '0;
          if (byte_in != '0) begin
            res_valid = 1'b1;
            res.kind  = KIND_FILL;
            res.addr  = off_r & ADDR_MASK;
            res.data  = held_r;
            res.len   = {8'd0, byte_in};
          end
        end
        default: begin
          phase_nxt = PH_OFFSET;
          idx_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OFFSET;
      off_r   <= '0;
      left_r  <= '0;
      held_r  <= '0;
      idx_r   <= '0;
      ended_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      left_r  <= left_nxt;
      held_r  <= held_nxt;
      idx_r   <= idx_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

// ===== rtl/prp_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_out_reg
// Result register: holds one command until the receiver takes it.
// ----------------------------------------------------------------------------
module prp_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic                 load_valid,
  input  prp_pkg::prp_result_t load_res,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output prp_pkg::prp_result_t out_res
);
  import prp_pkg::*;

  logic        valid_r;
  prp_result_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= load_valid;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // payload only moves on a load carrying a command
  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      res_r <= load_res;
    end
  end

endmodule

// ===== rtl/patch_record_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patch_record_parser_core
// IPS / APS patch record body parser producing ROM write and fill commands.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the record body of a patch, one byte per transfer, on the in_
//   channel (valid/ready). Each byte yields zero or one command on the out_
//   channel: write one byte, fill a run, or patch ended. After the end
//   command every later byte is taken and dropped.
//   Configure patch_format (index 0) and rom_size (index 1) through the
//   cfg_ write port while the block is idle.
// Timing:
//   One byte per cycle sustained while out_ready stays high. A byte is
//   held in the input register, then the parser step writes its command
//   into the result register, from which the command is offered.
//   The single parser step per cycle sets the rate.
// Reset:
//   rst_n (synchronous, active low) empties both registers, returns the
//   parser to the first offset byte and restores IPS format and
//   rom_size = all ones.
// Stall:
//   While out_ready is low and a command is held, the parser holds its
//   input byte; in_ready drops once the input register is full too.
// ----------------------------------------------------------------------------
module patch_record_parser_core #(
  parameter int unsigned ADDRESS_WIDTH = prp_pkg::ADDR_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [prp_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [prp_pkg::DATA_W-1:0]  in_patch_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [prp_pkg::KIND_W-1:0]  out_command_kind,
  output logic [prp_pkg::ADDR_W-1:0]  out_target_address,
  output logic [prp_pkg::DATA_W-1:0]  out_data_value,
  output logic [prp_pkg::LEN_W-1:0]   out_run_length
);
  import prp_pkg::*;

  // configuration registers
  logic             aps_r;
  logic [CFG_W-1:0] rom_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aps_r      <= 1'b0;
      rom_size_r <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATCH_FORMAT: aps_r      <= cfg_data[0];
        REG_ROM_SIZE:     rom_size_r <= cfg_data;
        default:          ;
      endcase
    end
  end

  // input register
  logic              in_v_r;
  logic [DATA_W-1:0] in_byte_r;
  logic              step;
  logic              can_load;

  // advance the parser when a byte waits and the result slot frees up
  assign step     = in_v_r && can_load;
  assign in_ready = !in_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_patch_byte;
    end
  end

  logic        res_valid;
  prp_result_t res;
  prp_result_t out_res;

  prp_parser #(
    .ADDRESS_WIDTH(ADDRESS_WIDTH)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .byte_in  (in_byte_r),
    .aps      (aps_r),
    .rom_size (rom_size_r),
    .res_valid(res_valid),
    .res      (res)
  );

  prp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .load_valid(res_valid),
    .load_res  (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_command_kind   = out_res.kind;
  assign out_target_address = out_res.addr;
  assign out_data_value     = out_res.data;
  assign out_run_length     = out_res.len;

endmodule
